>>> rtl/wsdf_pkg.sv
// Shared types, codes and helpers for the WebSocket frame deframer.
package wsdf_pkg;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;
  localparam logic [31:0] CTRL_MAX_LEN    = 32'd125;
  localparam logic [6:0]  LEN7_EXT16      = 7'd126;
  localparam logic [6:0]  LEN7_EXT64      = 7'd127;
  localparam logic [2:0]  EXT16_LEFT      = 3'd1;
  localparam logic [2:0]  EXT64_LEFT      = 3'd7;
  localparam logic [2:0]  EXT_HIGH_FIRST  = 3'd4;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_EMPTY = 2'd1,
    EV_PROTO = 2'd2,
    EV_BIG   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    RP_DELIVER = 2'd0,
    RP_PONG    = 2'd1,
    RP_CLOSE   = 2'd2,
    RP_IGNORE  = 2'd3
  } reply_e;

  function automatic reply_e reply_for(input logic [3:0] op);
    reply_e r;
    case (op)
      OP_TEXT, OP_BINARY: r = RP_DELIVER;
      OP_PING:            r = RP_PONG;
      OP_CLOSE:           r = RP_CLOSE;
      default:            r = RP_IGNORE;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/websocket_frame_deframer_core.sv
// WebSocket client-to-server deframer: header parse, unmasking and error reporting.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: rx_byte
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: payload_byte, tuser: event,
//                                                      kind, reply; tlast: last
//  cfg       in         cfg_we_i                       cfg_wdata_i: max_payload
//
// One byte is taken every cycle while s_axis_tready is high; its result, if any, appears in the output register
// on the next cycle. A waiting result stalls input only while m_axis_tready is low.
// Reset clears the parser to expect a first header byte and sets max_payload to 1024.
// After an error or a completed close frame every word is taken and dropped until reset.
module websocket_frame_deframer_core
  import wsdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
  output logic [7:0]  m_axis_tuser,   // [1:0] event_res, [5:2] frame_kind, [7:6] reply
  output logic        m_axis_tlast    // last
);

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [2:0]  len_left_q, len_left_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic        len_high_q, len_high_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_cnt_q, key_cnt_d;
  logic [15:0] remain_q, remain_d;
  logic [1:0]  mask_pos_q, mask_pos_d;
  logic [15:0] max_payload_q;

  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [7:0]  out_user_q, out_user_d;
  logic        out_last_q, out_last_d;
  logic        emit;

  logic        in_fire;
  logic [7:0]  b;
  logic [31:0] chk_acc;
  logic        chk_high;
  logic        chk_big, chk_proto;
  logic [7:0]  key_byte;
  reply_e      cur_reply;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cur_reply     = reply_for(opcode_q);

  // Length as it stands once this byte is folded in, for the checks at length end.
  assign chk_acc   = (phase_q == PH_HDR1) ? {25'd0, b[6:0]} : {len_acc_q[23:0], b};
  assign chk_high  = (phase_q == PH_HDR1) ? 1'b0 : len_high_q;
  assign chk_proto = !chk_high && opcode_q[3] && (chk_acc > CTRL_MAX_LEN);
  assign chk_big   = chk_high || (!chk_proto && (chk_acc > {16'd0, max_payload_q}));

  always_comb begin
    case (mask_pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    len_left_d = len_left_q;
    len_acc_d  = len_acc_q;
    len_high_d = len_high_q;
    key_d      = key_q;
    key_cnt_d  = key_cnt_q;
    remain_d   = remain_q;
    mask_pos_d = mask_pos_q;
    emit       = 1'b0;
    out_byte_d = 8'd0;
    out_user_d = {RP_CLOSE, opcode_q, EV_PROTO};
    out_last_d = 1'b0;

    case (phase_q)
      PH_HDR0: begin
        opcode_d = b[3:0];
        phase_d  = PH_HDR1;
      end
      PH_HDR1: begin
        len_high_d = 1'b0;
        len_acc_d  = 32'd0;
        if (!b[7]) begin
          emit    = 1'b1;
          phase_d = PH_HALT;
        end else if (b[6:0] == LEN7_EXT16) begin
          len_left_d = EXT16_LEFT;
          phase_d    = PH_EXTLEN;
        end else if (b[6:0] == LEN7_EXT64) begin
          len_left_d = EXT64_LEFT;
          phase_d    = PH_EXTLEN;
        end else begin
          len_acc_d = chk_acc;
          if (chk_proto || chk_big) begin
            emit       = 1'b1;
            out_user_d = {RP_CLOSE, opcode_q, chk_proto ? EV_PROTO : EV_BIG};
            phase_d    = PH_HALT;
          end else begin
            remain_d  = chk_acc[15:0];
            key_d     = 32'd0;
            key_cnt_d = 2'd0;
            phase_d   = PH_MASK;
          end
        end
      end
      PH_EXTLEN: begin
        // The upper four bytes of a 64-bit length only flag overflow.
        if (len_left_q >= EXT_HIGH_FIRST) begin
          if (b != 8'd0) len_high_d = 1'b1;
        end else begin
          len_acc_d = chk_acc;
        end
        if (len_left_q == 3'd0) begin
          if (chk_proto || chk_big) begin
            emit       = 1'b1;
            out_user_d = {RP_CLOSE, opcode_q, chk_proto ? EV_PROTO : EV_BIG};
            phase_d    = PH_HALT;
          end else begin
            remain_d  = chk_acc[15:0];
            key_d     = 32'd0;
            key_cnt_d = 2'd0;
            phase_d   = PH_MASK;
          end
        end else begin
          len_left_d = len_left_q - 3'd1;
        end
      end
      PH_MASK: begin
        key_d = {key_q[23:0], b};
        if (key_cnt_q != 2'd3) begin
          key_cnt_d = key_cnt_q + 2'd1;
        end else begin
          key_cnt_d  = 2'd0;
          mask_pos_d = 2'd0;
          if (remain_q == 16'd0) begin
            emit       = 1'b1;
            out_user_d = {cur_reply, opcode_q, EV_EMPTY};
            out_last_d = 1'b1;
            phase_d    = (opcode_q == OP_CLOSE) ? PH_HALT : PH_HDR0;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit       = 1'b1;
        out_byte_d = b ^ key_byte;
        out_user_d = {cur_reply, opcode_q, EV_DATA};
        out_last_d = (remain_q == 16'd1);
        mask_pos_d = mask_pos_q + 2'd1;
        remain_d   = remain_q - 16'd1;
        if (remain_q == 16'd1) begin
          phase_d = (opcode_q == OP_CLOSE) ? PH_HALT : PH_HDR0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HDR0;
      opcode_q      <= 4'd0;
      len_left_q    <= 3'd0;
      len_acc_q     <= 32'd0;
      len_high_q    <= 1'b0;
      key_q         <= 32'd0;
      key_cnt_q     <= 2'd0;
      remain_q      <= 16'd0;
      mask_pos_q    <= 2'd0;
      max_payload_q <= MAX_PAYLOAD_RST;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) max_payload_q <= cfg_wdata_i;
      if (in_fire) begin
        phase_q    <= phase_d;
        opcode_q   <= opcode_d;
        len_left_q <= len_left_d;
        len_acc_q  <= len_acc_d;
        len_high_q <= len_high_d;
        key_q      <= key_d;
        key_cnt_q  <= key_cnt_d;
        remain_q   <= remain_d;
        mask_pos_q <= mask_pos_d;
      end
      if (in_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_byte_q <= out_byte_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> verif/websocket_frame_deframer_core_tb.sv
// Self-checking testbench for the WebSocket frame deframer core.
`timescale 1ns / 1ps

module websocket_frame_deframer_core_tb;
  import wsdf_pkg::*;

  localparam int unsigned LEN7_MAX   = 125;
  localparam int unsigned BIG_FRAME  = 600;
  localparam int unsigned ITEMS      = 2000;
  localparam int unsigned NUM_LIMITS = 6;
  localparam int unsigned DRAIN      = 20;
  // Longest correct quiet stretch is a sender gap plus a receiver stall plus a
  // register write pause; this is many times that.
  localparam int unsigned IDLE_LIMIT = 1000;

  typedef enum int unsigned {LEN_FMT_7, LEN_FMT_16, LEN_FMT_64} len_fmt_e;
  typedef enum int unsigned {
    END_UNMASKED, END_HIGH_LEN, END_CTRL_LONG, END_OVER_LIMIT, END_CLOSE
  } end_kind_e;

  typedef struct {
    event_e     ev;
    logic [7:0] data;
    logic [3:0] kind;
    reply_e     rep;
    logic       last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] payload_byte
  logic [7:0]  m_axis_tuser;        // [1:0] event_res, [5:2] frame_kind, [7:6] reply
  logic        m_axis_tlast;        // last

  websocket_frame_deframer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stimulus and expected results.
  logic [7:0]  rx_stream[$];
  result_t     deframed_q[$];
  int unsigned mismatches = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned event_count[4] = '{0, 0, 0, 0};
  int unsigned limit_now = MAX_PAYLOAD_RST;
  end_kind_e   end_kind = END_CLOSE;

  // Handshake flags of the last rising edge, read by the falling-edge drivers.
  bit          in_fired = 1'b0;
  bit          out_fired = 1'b0;
  int unsigned in_hold = 0;
  int unsigned out_hold = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // Parser copy.
  logic [15:0] max_len = MAX_PAYLOAD_RST;
  phase_e      rx_phase = PH_HDR0;
  logic [3:0]  opcode = '0;
  logic [2:0]  ext_left = '0;
  logic [31:0] len_acc = '0;
  logic        hi_seen = 1'b0;
  logic [31:0] key = '0;
  logic [1:0]  key_cnt = '0;
  logic [31:0] remaining = '0;
  logic [1:0]  key_pos = '0;

  function automatic reply_e reply_of(input logic [3:0] op);
    if (op == OP_TEXT || op == OP_BINARY) return RP_DELIVER;
    if (op == OP_PING) return RP_PONG;
    if (op == OP_CLOSE) return RP_CLOSE;
    return RP_IGNORE;
  endfunction

  function automatic void emit(input event_e ev, input logic [7:0] data, input reply_e rep,
                               input logic last);
    result_t r;
    r.ev = ev;
    r.data = data;
    r.kind = opcode;
    r.rep = rep;
    r.last = last;
    deframed_q.push_back(r);
  endfunction

  function automatic void abort_stream(input event_e ev);
    emit(ev, 8'h00, RP_CLOSE, 1'b0);
    rx_phase = PH_HALT;
  endfunction

  // A close frame stops the parser for good, any other frame returns to the header.
  function automatic void end_frame();
    rx_phase = (opcode == OP_CLOSE) ? PH_HALT : PH_HDR0;
  endfunction

  // The control-frame limit is checked ahead of the register limit.
  function automatic void finish_length();
    if (hi_seen) abort_stream(EV_BIG);
    else if (opcode[3] && len_acc > CTRL_MAX_LEN) abort_stream(EV_PROTO);
    else if (len_acc > {16'h0000, max_len}) abort_stream(EV_BIG);
    else begin
      remaining = len_acc;
      key = '0;
      key_cnt = '0;
      rx_phase = PH_MASK;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] kb;
    case (rx_phase)
      PH_HDR0: begin
        opcode = b[3:0];
        rx_phase = PH_HDR1;
      end
      PH_HDR1: begin
        if (!b[7]) abort_stream(EV_PROTO);
        else begin
          hi_seen = 1'b0;
          len_acc = '0;
          if (b[6:0] == LEN7_EXT16) begin
            ext_left = EXT16_LEFT;
            rx_phase = PH_EXTLEN;
          end else if (b[6:0] == LEN7_EXT64) begin
            ext_left = EXT64_LEFT;
            rx_phase = PH_EXTLEN;
          end else begin
            len_acc = {25'd0, b[6:0]};
            finish_length();
          end
        end
      end
      PH_EXTLEN: begin
        // The upper four bytes of a 64-bit length only matter as nonzero or not.
        if (ext_left >= EXT_HIGH_FIRST) begin
          if (b != 8'h00) hi_seen = 1'b1;
        end else begin
          len_acc = {len_acc[23:0], b};
        end
        if (ext_left == 3'd0) finish_length();
        else ext_left = ext_left - 3'd1;
      end
      PH_MASK: begin
        key = {key[23:0], b};
        if (key_cnt != 2'd3) key_cnt = key_cnt + 2'd1;
        else begin
          key_cnt = '0;
          key_pos = '0;
          if (remaining == 0) begin
            emit(EV_EMPTY, 8'h00, reply_of(opcode), 1'b1);
            end_frame();
          end else begin
            rx_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        kb = key[8 * (3 - int'(key_pos)) +: 8];
        emit(EV_DATA, b ^ kb, reply_of(opcode), remaining == 32'd1);
        key_pos = key_pos + 2'd1;
        remaining = remaining - 32'd1;
        if (remaining == 0) end_frame();
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_word();
    result_t want;
    if (deframed_q.size() == 0) begin
      $error("unexpected output word: tuser %h tdata %h tlast %b",
             m_axis_tuser, m_axis_tdata, m_axis_tlast);
      mismatches++;
    end else begin
      want = deframed_q.pop_front();
      event_count[want.ev]++;
      check_field("event_res", want.ev, m_axis_tuser[1:0]);
      check_field("payload_byte", want.data, m_axis_tdata);
      check_field("frame_kind", want.kind, m_axis_tuser[5:2]);
      check_field("reply", want.rep, m_axis_tuser[7:6]);
      check_field("last", want.last, m_axis_tlast);
    end
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  always @(posedge clk_i) begin
    in_fired = 1'b0;
    out_fired = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) max_len = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        out_fired = 1'b1;
        check_word();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_fired = 1'b1;
        deframe_byte(s_axis_tdata);
      end
    end
  end

  // Byte sender: a random gap before each word, with calm stretches now and then.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fired) begin
      if (in_hold > 0) begin
        in_hold--;
        s_axis_tvalid <= 1'b0;
      end else if (rx_stream.size() > 0) begin
        s_axis_tdata <= rx_stream.pop_front();
        s_axis_tvalid <= 1'b1;
        words_in++;
        if (words_in % 64 == 0) in_calm = ($urandom_range(0, 3) == 0);
        in_hold = draw_wait(in_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: each word waits out its own drawn stall.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fired) begin
        words_out++;
        if (words_out % 64 == 0) out_calm = ($urandom_range(0, 3) == 0);
        out_hold = draw_wait(out_calm);
      end
      if (out_hold > 0 && m_axis_tvalid) begin
        out_hold--;
        m_axis_tready <= 1'b0;
      end else if (out_hold > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Stream stalled for %0d cycles with %0d results outstanding.",
                 quiet_cycles, deframed_q.size());
        $display("** websocket_frame_deframer_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (rx_stream.size() != 0 || s_axis_tvalid || deframed_q.size() != 0)
      @(posedge clk_i);
    // Header bytes give no result, so the wait goes on past the point where the queues are empty.
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_now = value;
  endtask

  task automatic push_frame(input logic [3:0] op, input int unsigned len, input len_fmt_e fmt,
                            input bit masked, input logic [31:0] len_hi, input bit with_body);
    logic [3:0]  flags;
    logic [31:0] mkey;
    logic [6:0]  len7;
    flags = 4'($urandom);
    mkey = $urandom;
    case (fmt)
      LEN_FMT_16: len7 = LEN7_EXT16;
      LEN_FMT_64: len7 = LEN7_EXT64;
      default:    len7 = len[6:0];
    endcase
    // FIN and RSV bits are random; the parser does not look at them.
    rx_stream.push_back({flags, op});
    rx_stream.push_back({masked, len7});
    if (fmt == LEN_FMT_16) begin
      rx_stream.push_back(len[15:8]);
      rx_stream.push_back(len[7:0]);
    end else if (fmt == LEN_FMT_64) begin
      for (int i = 3; i >= 0; i--) rx_stream.push_back(len_hi[8 * i +: 8]);
      for (int i = 3; i >= 0; i--) rx_stream.push_back(len[8 * i +: 8]);
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) rx_stream.push_back(mkey[8 * i +: 8]);
      if (with_body) repeat (len) rx_stream.push_back(8'($urandom));
    end
  endtask

  // A well-formed frame of any opcode but close, within every length limit.
  task automatic push_good_frame();
    logic [3:0]  op;
    len_fmt_e    fmt;
    int unsigned cap;
    int unsigned pick;
    int unsigned len;
    do op = 4'($urandom); while (op == OP_CLOSE);
    fmt = len_fmt_e'($urandom_range(LEN_FMT_7, LEN_FMT_64));
    cap = limit_now;
    if (op[3] && cap > CTRL_MAX_LEN) cap = CTRL_MAX_LEN;
    if (fmt == LEN_FMT_7 && cap > LEN7_MAX) cap = LEN7_MAX;
    if (cap > BIG_FRAME) cap = BIG_FRAME;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = 0;
    else if (pick == 1) len = cap;
    else if (pick <= 3) len = $urandom_range(0, cap);
    else len = $urandom_range(0, (cap < 12) ? cap : 12);
    push_frame(op, len, fmt, 1'b1, 32'h0, 1'b1);
  endtask

  // Errors and close frames stop the parser until reset, so each run ends on one of them.
  task automatic push_final_frame();
    logic [3:0] op;
    end_kind = end_kind_e'($urandom_range(END_UNMASKED, END_CLOSE));
    op = 4'($urandom);
    case (end_kind)
      END_UNMASKED:
        push_frame(op, $urandom_range(0, LEN7_MAX), LEN_FMT_7, 1'b0, 32'h0, 1'b0);
      END_HIGH_LEN:
        push_frame(op, $urandom_range(0, 8), LEN_FMT_64, 1'b1,
                   $urandom_range(1, 32'hFFFF_FFFF), 1'b0);
      END_CTRL_LONG:
        push_frame({1'b1, op[2:0]}, $urandom_range(CTRL_MAX_LEN + 1, 16'hFFFF), LEN_FMT_16,
                   1'b1, 32'h0, 1'b0);
      END_OVER_LIMIT:
        push_frame({1'b0, op[2:0]}, limit_now + 1 + $urandom_range(0, 1000), LEN_FMT_64,
                   1'b1, 32'h0, 1'b0);
      default:
        push_frame(OP_CLOSE, $urandom_range(0, 8), LEN_FMT_7, 1'b1, 32'h0, 1'b1);
    endcase
    repeat (40) rx_stream.push_back(8'($urandom));
  endtask

  initial begin
    logic [15:0] limit;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Ping of two bytes with an all-ones key: payload 00 and FF come out inverted.
    rx_stream = '{{4'h8, OP_PING}, 8'h82, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    push_frame(OP_TEXT, 0, LEN_FMT_7, 1'b1, 32'h0, 1'b1);
    push_frame(OP_BINARY, 1, LEN_FMT_16, 1'b1, 32'h0, 1'b1);
    push_frame(OP_PONG, 0, LEN_FMT_64, 1'b1, 32'h0, 1'b1);

    for (int unsigned k = 0; k < NUM_LIMITS; k++) begin
      case (k)
        0: limit = 16'd0;
        1: limit = 16'hFFFF;
        2: limit = 16'($urandom_range(1, 300));
        3: limit = CTRL_MAX_LEN[15:0];
        4: limit = 16'd1;
        default: limit = 16'($urandom);
      endcase
      write_max_len(limit);
      while (words_in + rx_stream.size() < (k + 1) * ITEMS / NUM_LIMITS) begin
        push_good_frame();
        // Keep the queue short so gaps and stalls stay spread over the run.
        while (rx_stream.size() > 64) @(posedge clk_i);
      end
    end
    push_final_frame();

    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
    $display("Sent %0d bytes over %0d max_payload settings; run ended on %s.",
             words_in, NUM_LIMITS + 1, end_kind.name());
    $display("Checked %0d data, %0d empty-frame, %0d protocol-error, %0d too-large words.",
             event_count[EV_DATA], event_count[EV_EMPTY], event_count[EV_PROTO],
             event_count[EV_BIG]);
    if (mismatches == 0) begin
      $display("** websocket_frame_deframer_core: PASSED **");
    end else begin
      $display("** websocket_frame_deframer_core: FAILED **");
    end
    $finish;
  end

endmodule
